// ===== rtl/assert_macros.svh =====
// Assertion macros used by the decoder unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge of clk_i outside reset
`define FUD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check an implication at every rising edge of clk_i outside reset
`define FUD_ASSERT_IMPL(label, cond, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (prop)) \
    else $error(msg);

`endif

// ===== rtl/fud_pkg.sv =====
// Types and constants of the form-urlencoded decoder
package fud_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned KindW = 2;
  localparam int unsigned EscW  = 2;

  // Result kinds
  localparam logic [KindW-1:0] KIND_KEY      = 2'd0;
  localparam logic [KindW-1:0] KIND_VALUE    = 2'd1;
  localparam logic [KindW-1:0] KIND_KEY_END  = 2'd2;
  localparam logic [KindW-1:0] KIND_PAIR_END = 2'd3;

  // Escape positions
  localparam logic [EscW-1:0] ESC_NONE = 2'd0;
  localparam logic [EscW-1:0] ESC_HIGH = 2'd1;
  localparam logic [EscW-1:0] ESC_LOW  = 2'd2;

  // Delimiters and hex digit mapping
  localparam logic [ByteW-1:0] CH_EQ        = 8'h3D;
  localparam logic [ByteW-1:0] CH_AMP       = 8'h26;
  localparam logic [ByteW-1:0] CH_PCT       = 8'h25;
  localparam logic [ByteW-1:0] DIGIT_MAX    = 8'd57;
  localparam logic [ByteW-1:0] ALPHA_OFFSET = 8'd55;
  localparam logic [ByteW-1:0] DIGIT_OFFSET = 8'd48;
  localparam int unsigned      NibbleShift  = 4;

  // Result queue
  localparam int unsigned QDepth   = 4;
  localparam int unsigned QPtrW    = $clog2(QDepth);
  localparam int unsigned QCntW    = $clog2(QDepth + 1);
  localparam int unsigned MaxRes   = 3;
  localparam int unsigned ResIdxW  = $clog2(MaxRes + 1);

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [ByteW-1:0] decoded_byte;
    logic             run_last;
  } res_t;

endpackage

// ===== rtl/fud_req_if.sv =====
// Request channel carrying encoded text bytes
interface fud_req_if;
  import fud_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] text_byte;
  logic             final_byte;

  modport source (output valid, output text_byte, output final_byte, input ready);
  modport sink (input valid, input text_byte, input final_byte, output ready);
endinterface

// ===== rtl/fud_res_if.sv =====
// Result channel carrying decoded bytes and marks
interface fud_res_if;
  import fud_pkg::*;

  logic             valid;
  logic             ready;
  logic [KindW-1:0] kind;
  logic [ByteW-1:0] decoded_byte;
  logic             run_last;

  modport source (output valid, output kind, output decoded_byte, output run_last,
                  input ready);
  modport sink (input valid, input kind, input decoded_byte, input run_last,
                output ready);
endinterface

// ===== rtl/form_urlencoded_decoder_unit.sv =====
// Form-urlencoded decoder: encoded bytes in, decoded key/value bytes and marks out
//
// req_i takes one encoded byte per request, with final_byte on the last byte of
// a text. res_o gives the decoded stream: key bytes, value bytes, a key-end mark
// at '=' in a key and a pair-end mark at '&' in a value or at the end of the
// text. '%' takes the next two bytes as hex digits. run_last flags the last
// result of each request. A request is decoded in the cycle it is accepted and
// its 0 to 3 results are written into a 4-entry result queue, whose head is
// shown on res_o. req_i is ready while at most one result is queued, so while
// res_o is ready a stream in which each byte yields at most one result runs at
// one byte per cycle. After a final byte that yields two or three results,
// req_i waits until the queue has drained to one result, as the single result
// read port of the queue drains one entry a cycle. When res_o stalls, the queue
// holds its results and req_i drops ready once two results wait. Reset empties
// the queue and returns the decoder to key parsing with no escape pending.
module form_urlencoded_decoder_unit (
  input  logic  clk_i,
  input  logic  rst_ni,
  fud_req_if.sink   req_i,
  fud_res_if.source res_o
);
  import fud_pkg::*;

  logic             in_value_q, in_value_d;
  logic [EscW-1:0]  esc_q, esc_d;
  logic [ByteW-1:0] high_q, high_d;

  res_t             que_q [QDepth];
  logic [QPtrW-1:0] head_q, tail_q;
  logic [QCntW-1:0] cnt_q;

  logic             req_acc, res_pop;
  logic [ByteW-1:0] nibble;
  logic             has_first, closed_pair;
  res_t             first_res;
  res_t             ent [MaxRes];
  logic [ResIdxW-1:0] n_res;

  assign req_acc     = req_i.valid && req_i.ready;
  assign req_i.ready = (cnt_q <= QCntW'(1));
  assign res_pop     = res_o.valid && res_o.ready;

  assign nibble = (req_i.text_byte > DIGIT_MAX) ? (req_i.text_byte - ALPHA_OFFSET)
                                                : (req_i.text_byte - DIGIT_OFFSET);

  // Decode one byte and work out the next parser state
  always_comb begin
    in_value_d  = in_value_q;
    esc_d       = esc_q;
    high_d      = high_q;
    has_first   = 1'b0;
    closed_pair = 1'b0;
    first_res   = '0;
    case (esc_q)
      ESC_HIGH: begin
        high_d = nibble << NibbleShift;
        esc_d  = ESC_LOW;
      end
      ESC_LOW: begin
        has_first              = 1'b1;
        first_res.kind         = in_value_q ? KIND_VALUE : KIND_KEY;
        first_res.decoded_byte = high_q + nibble;
        esc_d                  = ESC_NONE;
      end
      default: begin
        if (req_i.text_byte == CH_PCT) begin
          esc_d = ESC_HIGH;
        end else if (!in_value_q && req_i.text_byte == CH_EQ) begin
          has_first      = 1'b1;
          first_res.kind = KIND_KEY_END;
          in_value_d     = 1'b1;
        end else if (in_value_q && req_i.text_byte == CH_AMP) begin
          has_first      = 1'b1;
          first_res.kind = KIND_PAIR_END;
          in_value_d     = 1'b0;
          closed_pair    = 1'b1;
        end else begin
          esc_d                  = ESC_NONE;
          has_first              = 1'b1;
          first_res.kind         = in_value_q ? KIND_VALUE : KIND_KEY;
          first_res.decoded_byte = req_i.text_byte;
        end
      end
    endcase

    // Build the result list, stream end repairs included
    for (int i = 0; i < MaxRes; i++) begin
      ent[i] = '0;
    end
    n_res = '0;
    if (has_first) begin
      ent[0] = first_res;
      n_res  = ResIdxW'(1);
    end
    if (req_i.final_byte) begin
      if (in_value_d) begin
        ent[n_res].kind = KIND_PAIR_END;
        n_res           = n_res + ResIdxW'(1);
      end else if (!closed_pair) begin
        ent[n_res].kind = KIND_KEY_END;
        n_res           = n_res + ResIdxW'(1);
        ent[n_res].kind = KIND_PAIR_END;
        n_res           = n_res + ResIdxW'(1);
      end
      esc_d      = ESC_NONE;
      high_d     = '0;
      in_value_d = 1'b0;
    end
    if (n_res != '0) begin
      ent[n_res - ResIdxW'(1)].run_last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_value_q <= 1'b0;
      esc_q      <= ESC_NONE;
      high_q     <= '0;
      head_q     <= '0;
      tail_q     <= '0;
      cnt_q      <= '0;
    end else begin
      if (req_acc) begin
        in_value_q <= in_value_d;
        esc_q      <= esc_d;
        high_q     <= high_d;
        tail_q     <= tail_q + QPtrW'(n_res);
      end
      if (res_pop) begin
        head_q <= head_q + QPtrW'(1);
      end
      cnt_q <= cnt_q + (req_acc ? QCntW'(n_res) : QCntW'(0)) - QCntW'(res_pop);
    end
  end

  // Queue storage: push up to three results at the tail
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MaxRes; i++) begin
      if (req_acc && (ResIdxW'(i) < n_res)) begin
        que_q[tail_q + QPtrW'(i)] <= ent[i];
      end
    end
  end

  assign res_o.valid        = (cnt_q != '0);
  assign res_o.kind         = que_q[head_q].kind;
  assign res_o.decoded_byte = que_q[head_q].decoded_byte;
  assign res_o.run_last     = que_q[head_q].run_last;

`include "assert_macros.svh"

  `FUD_ASSERT(a_cnt_bound, cnt_q <= QCntW'(QDepth), "result queue overflow")
  `FUD_ASSERT_IMPL(a_acc_room, req_acc, cnt_q <= QCntW'(1), "request taken without queue room")
  `FUD_ASSERT(a_esc_code, esc_q == ESC_NONE || esc_q == ESC_HIGH || esc_q == ESC_LOW,
              "escape position reached unused code")
  `FUD_ASSERT_IMPL(a_final_reset, req_acc && req_i.final_byte,
                   ##1 (!in_value_q && esc_q == ESC_NONE && high_q == '0),
                   "parser state not cleared after final byte")

endmodule
